/* hw/rtl/npt_pkg.sv */
// Shared types and constants for the nearest point table.
// No dependencies.
`timescale 1ns / 1ps

package npt_pkg;

	localparam int COORD_W = 20;
	localparam int DIST_W  = 42;

	// squared distance limit in eighth units squared (64 * 999999999)
	localparam logic [DIST_W-1:0] FAR_LIMIT = 42'd63999999936;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_SEARCH = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_BAD_IDX = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic ld_new;
		logic ld_nbr;
	} cell_ctl_t;

endpackage

/* hw/rtl/npt_cell.sv */
// One table cell: holds a point, loads a new point or its neighbor's point.
// Depends on npt_pkg.
`timescale 1ns / 1ps

module npt_cell (
	input  logic               clk,
	input  npt_pkg::cell_ctl_t ctl,
	input  npt_pkg::point_t    new_point,
	input  npt_pkg::point_t    nbr_point,
	output npt_pkg::point_t    point
);

	npt_pkg::point_t point_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_new) begin
			point_q <= new_point;
		end else if (ctl.ld_nbr) begin
			point_q <= nbr_point;
		end
	end

	assign point = point_q;

endmodule

/* hw/rtl/npt_dist.sv */
// Squared distance pipeline and running minimum for search.
// Depends on npt_pkg.
`timescale 1ns / 1ps

module npt_dist #(
	parameter int IW = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          feed,
	input  logic [IW-1:0]                 feed_idx,
	input  npt_pkg::point_t               query,
	input  npt_pkg::point_t               point,
	output logic                          found,
	output logic [IW-1:0]                 best_idx,
	output logic [npt_pkg::DIST_W-1:0]    best_dist
);

	localparam int DW = npt_pkg::DIST_W;
	localparam int MW = npt_pkg::COORD_W + 1;

	logic          vld_s1, vld_s2, vld_s3;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	logic [MW-1:0] ax_s1, ay_s1, az_s1;
	logic [DW-1:0] sx_s2, sy_s2, sz_s2;
	logic [DW-1:0] sum_s3;
	logic          found_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] best_q;
	logic signed [MW-1:0] dx, dy, dz;

	always_comb begin
		dx = {query.x[MW-2], query.x} - {point.x[MW-2], point.x};
		dy = {query.y[MW-2], query.y} - {point.y[MW-2], point.y};
		dz = {query.z[MW-2], query.z} - {point.z[MW-2], point.z};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= feed;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (start) begin
				found_q <= 1'b0;
			end else if (vld_s3 && sum_s3 < best_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= feed_idx;
		ax_s1  <= dx[MW-1] ? MW'(-dx) : MW'(dx);
		ay_s1  <= dy[MW-1] ? MW'(-dy) : MW'(dy);
		az_s1  <= dz[MW-1] ? MW'(-dz) : MW'(dz);
		idx_s2 <= idx_s1;
		sx_s2  <= DW'(ax_s1 * ax_s1);
		sy_s2  <= DW'(ay_s1 * ay_s1);
		sz_s2  <= DW'(az_s1 * az_s1);
		idx_s3 <= idx_s2;
		// three squares stay below 2^42
		sum_s3 <= sx_s2 + sy_s2 + sz_s2;
		if (start) begin
			best_q <= npt_pkg::FAR_LIMIT;
			idx_q  <= '0;
		end else if (vld_s3 && sum_s3 < best_q) begin
			best_q <= sum_s3;
			idx_q  <= idx_s3;
		end
	end

	assign found     = found_q;
	assign best_idx  = idx_q;
	assign best_dist = best_q;

endmodule

/* hw/rtl/nearest_point_table.sv */
// Insert, delete, clear: the request goes to ST_FIN, which registers the result.
// Search: ST_SCAN, ST_DRAIN, then ST_FIN; the point ring rotates once through the
// distance pipeline, one entry per cycle. One request in flight at a time.
// A waiting result does not block the next request from being taken.
// Reset clears the entry count and handshake state; points are not cleared.
`timescale 1ns / 1ps

module nearest_point_table #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // pos_x, pos_y, pos_z, entry_index, zero pad
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // nearest_index, nearest_dist_sq, entry_count, zero pad
	output logic [2:0]  m_tuser    // status, found
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int DW   = npt_pkg::DIST_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIN} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   scan_q;
	logic [1:0]      drain_q;
	logic [1:0]      status_q;
	logic            search_q;
	npt_pkg::point_t query_q;
	logic            m_tvalid_q;
	logic [63:0]     m_tdata_q;
	logic [2:0]      m_tuser_q;

	npt_pkg::point_t in_point;
	npt_pkg::point_t pts [TABLE_DEPTH];
	logic [CMPW-1:0] del_idx, count_x;
	logic            accept, out_free, do_insert, do_delete, rotate;
	logic            found;
	logic [IW-1:0]   best_idx;
	logic [DW-1:0]   best_dist;

	assign in_point = '{z: s_tdata[59:40], y: s_tdata[39:20], x: s_tdata[19:0]};
	assign del_idx  = CMPW'(s_tdata[66:60]);
	assign count_x  = CMPW'(count_q);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign do_insert = accept && s_tuser == npt_pkg::MODE_INSERT
		&& count_q != CW'(TABLE_DEPTH);
	assign do_delete = accept && s_tuser == npt_pkg::MODE_DELETE && del_idx < count_x;
	assign rotate    = (state_q == ST_SCAN);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		npt_pkg::cell_ctl_t ctl;
		always_comb begin
			ctl.ld_new = do_insert && count_q == CW'(i);
			ctl.ld_nbr = rotate || (do_delete && CMPW'(i) >= del_idx);
		end
		npt_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_point (in_point),
			.nbr_point (pts[(i + 1) % TABLE_DEPTH]),
			.point     (pts[i])
		);
	end

	npt_dist #(.IW(IW)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.feed      (rotate && CMPW'(scan_q) < count_x),
		.feed_idx  (scan_q),
		.query     (query_q),
		.point     (pts[0]),
		.found     (found),
		.best_idx  (best_idx),
		.best_dist (best_dist)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			drain_q    <= '0;
			status_q   <= npt_pkg::STATUS_OK;
			search_q   <= 1'b0;
			query_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// in ST_FIN the result register is reloaded below
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= npt_pkg::STATUS_OK;
						search_q <= 1'b0;
						state_q  <= ST_FIN;
						case (s_tuser)
							npt_pkg::MODE_INSERT: begin
								if (do_insert) begin
									count_q <= count_q + 1'b1;
								end else begin
									status_q <= npt_pkg::STATUS_FULL;
								end
							end
							npt_pkg::MODE_DELETE: begin
								if (do_delete) begin
									count_q <= count_q - 1'b1;
								end else begin
									status_q <= npt_pkg::STATUS_BAD_IDX;
								end
							end
							npt_pkg::MODE_CLEAR: count_q <= '0;
							default: begin
								search_q <= 1'b1;
								scan_q   <= '0;
								query_q  <= in_point;
								state_q  <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == IW'(TABLE_DEPTH - 1)) begin
						drain_q <= 2'd2;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 2'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= {search_q && found, status_q};
						m_tdata_q  <= {7'd0, 8'(count_q),
							(search_q && found) ? best_dist : DW'(0),
							(search_q && found) ? 7'(best_idx) : 7'd0};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hw/rtl/npt_checker.sv */
// Port-level checks for nearest_point_table, bound to the top level.
// Depends on npt_pkg and the nearest_point_table ports.
`timescale 1ns / 1ps

module npt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// held result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a result needs an accepted request in an earlier cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with no request in flight");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata[48:0] == 49'd0)
		else $error("miss carries index or distance");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == npt_pkg::STATUS_OK
			&& m_tdata[48:7] < npt_pkg::FAR_LIMIT)
		else $error("hit with bad status or distance");

endmodule

bind nearest_point_table npt_checker u_npt_checker (.*);
